/* hdl/rmv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmv_pkg
// types and fixed widths shared by the running mean and variance block
// ----------------------------------------------------------------------------
package rmv_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int MEAN_BITS   = SAMPLE_BITS + FRAC_BITS;
    localparam int AD_BITS     = MEAN_BITS + 1;
    localparam int M2_BITS     = 64;
    localparam int M2_SHIFT    = 2 * FRAC_BITS - 4;
    localparam int CNT_IN_BITS = 21;
    localparam int TOTAL_BITS  = 21;
    localparam int SPREAD_BITS = 48;
    localparam int STDEV_BITS  = 32;
    localparam int VAR_SHIFT   = 12;
    localparam int DIV_BITS    = M2_BITS + VAR_SHIFT;
    localparam int SQRT_BITS   = DIV_BITS / 2;
    localparam int DIV_STEPS   = DIV_BITS;
    localparam int SQRT_STEPS  = SQRT_BITS;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int IN_DATA_W   = 152;
    localparam int OUT_DATA_W  = 208;
    localparam int OUT_USER_W  = 2;

    typedef enum logic [16:0] {
        ST_IDLE  = 17'd1 << 0,
        ST_LOAD  = 17'd1 << 1,
        ST_MA_GO = 17'd1 << 2,
        ST_MA    = 17'd1 << 3,
        ST_DA_GO = 17'd1 << 4,
        ST_DA    = 17'd1 << 5,
        ST_MB_GO = 17'd1 << 6,
        ST_MB    = 17'd1 << 7,
        ST_MC_GO = 17'd1 << 8,
        ST_MC    = 17'd1 << 9,
        ST_FIN_A = 17'd1 << 10,
        ST_FIN_B = 17'd1 << 11,
        ST_DS_GO = 17'd1 << 12,
        ST_DS    = 17'd1 << 13,
        ST_SQ_GO = 17'd1 << 14,
        ST_SQ    = 17'd1 << 15,
        ST_DONE  = 17'd1 << 16
    } state_t;

    typedef enum logic [1:0] {
        MUL_DELTA_COUNT = 2'd0,
        MUL_DELTA_STEP  = 2'd1,
        MUL_BY_SEEN     = 2'd2
    } mul_sel_t;

    typedef enum logic {
        DIV_MEAN  = 1'b0,
        DIV_STATS = 1'b1
    } div_sel_t;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_MERGE = 1'b1
    } op_t;

    typedef struct packed {
        logic     capture;
        logic     load;
        logic     mul_go;
        mul_sel_t mul_sel;
        logic     mul_step;
        logic     div_go;
        div_sel_t div_sel;
        logic     div_step;
        logic     div_clear;
        logic     sqrt_go;
        logic     sqrt_step;
        logic     fin_a;
        logic     fin_b;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic refused;
        logic n_zero;
        logic few;
    } status_t;

endpackage

`default_nettype wire

/* hdl/rmv_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmv_ctrl
// sequencer stepping the shared multiplier, divider and square root
// ----------------------------------------------------------------------------
module rmv_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output rmv_pkg::cmd_t        cmd,
    input  wire rmv_pkg::status_t stat
);
    import rmv_pkg::*;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_MA_GO;
            end
            ST_MA_GO:
            begin
                if (stat.refused)
                begin
                    state_next = ST_DS_GO;
                end
                else
                begin
                    cmd.mul_go  = 1'b1;
                    cmd.mul_sel = MUL_DELTA_COUNT;
                    state_next  = ST_MA;
                end
            end
            ST_MA:
            begin
                if (stat.mul_done)
                begin
                    state_next = ST_DA_GO;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                end
            end
            ST_DA_GO:
            begin
                step_next = '0;
                if (stat.n_zero)
                begin
                    state_next = ST_MB_GO;
                end
                else
                begin
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = DIV_MEAN;
                    state_next  = ST_DA;
                end
            end
            ST_DA:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_MB_GO;
                end
            end
            ST_MB_GO:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_DELTA_STEP;
                state_next  = ST_MB;
            end
            ST_MB:
            begin
                if (stat.mul_done)
                begin
                    state_next = ST_MC_GO;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                end
            end
            ST_MC_GO:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_BY_SEEN;
                state_next  = ST_MC;
            end
            ST_MC:
            begin
                if (stat.mul_done)
                begin
                    state_next = ST_FIN_A;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                end
            end
            ST_FIN_A:
            begin
                cmd.fin_a  = 1'b1;
                state_next = ST_FIN_B;
            end
            ST_FIN_B:
            begin
                cmd.fin_b  = 1'b1;
                state_next = ST_DS_GO;
            end
            ST_DS_GO:
            begin
                step_next = '0;
                if (stat.few)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = DIV_STATS;
                    state_next  = ST_DS;
                end
            end
            ST_DS:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_SQ_GO;
                end
            end
            ST_SQ_GO:
            begin
                step_next   = '0;
                cmd.sqrt_go = 1'b1;
                state_next  = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/rmv_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmv_datapath
// running state, shift-add multiplier, restoring divider and square root
// ----------------------------------------------------------------------------
module rmv_datapath
#(
    parameter int COUNT_BITS = 20,
    parameter int CW         = COUNT_BITS + 1,
    parameter int NW         = ((CW > 21) ? CW : 21) + 1
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rmv_pkg::cmd_t                 cmd,
    output rmv_pkg::status_t                   stat,
    input  wire logic [rmv_pkg::IN_DATA_W-1:0] in_data,
    input  wire logic                          in_op,
    output logic [rmv_pkg::OUT_DATA_W-1:0]     out_data,
    output logic [rmv_pkg::OUT_USER_W-1:0]     out_user
);
    import rmv_pkg::*;

    localparam int PW  = (2 * AD_BITS + CW > M2_SHIFT + M2_BITS + 1)
                         ? 2 * AD_BITS + CW : M2_SHIFT + M2_BITS + 1;
    localparam int SRW = SQRT_BITS + 1;

    // running state
    logic [CW-1:0]             seen_reg;
    logic signed [MEAN_BITS-1:0] mean_reg;
    logic [M2_BITS-1:0]        m2_reg;

    // incoming partial
    logic [NW-1:0]             nb_reg;
    logic signed [MEAN_BITS-1:0] mb_reg;
    logic [M2_BITS-1:0]        m2b_reg;
    logic [AD_BITS-1:0]        ad_reg;
    logic                      neg_reg;
    logic [NW-1:0]             n_reg;
    logic                      refused_reg;

    // multiplier
    logic [PW-1:0]             mcand_reg;
    logic [AD_BITS-1:0]        mplier_reg;
    logic [PW-1:0]             acc_reg;

    // divider
    logic [DIV_BITS-1:0]       num_reg;
    logic [DIV_BITS-1:0]       quot_reg;
    logic [NW-1:0]             den_reg;
    logic [NW-1:0]             rem_reg;

    // square root
    logic [DIV_BITS-1:0]       rad_reg;
    logic [SQRT_BITS-1:0]      root_reg;
    logic [SRW-1:0]            srem_reg;

    // merge finish
    logic [M2_BITS-1:0]        term_reg;
    logic                      tovf_reg;
    logic [M2_BITS:0]          sum_reg;

    logic [OUT_DATA_W-1:0]     out_data_reg;
    logic [OUT_USER_W-1:0]     out_user_reg;

    logic [SAMPLE_BITS-1:0]    in_sample;
    logic [CNT_IN_BITS-1:0]    in_count;
    logic [MEAN_BITS-1:0]      in_mean;
    logic [M2_BITS-1:0]        in_m2;
    logic signed [AD_BITS-1:0] delta;
    logic [NW-1:0]             n_sum;
    logic [NW:0]               div_trial;
    logic                      div_ge;
    logic [SRW+1:0]            sq_r2;
    logic [SRW+1:0]            sq_trial;
    logic                      sq_ge;
    logic [PW:0]               rnd;
    logic [M2_BITS:0]          tot;
    logic [AD_BITS-1:0]        t_val;
    logic [AD_BITS-1:0]        mean_new;
    logic                      few;
    logic [SPREAD_BITS-1:0]    spread;
    logic [STDEV_BITS-1:0]     sd;

    assign in_sample = in_data[SAMPLE_BITS-1:0];
    assign in_count  = in_data[SAMPLE_BITS +: CNT_IN_BITS];
    assign in_mean   = in_data[SAMPLE_BITS + CNT_IN_BITS +: MEAN_BITS];
    assign in_m2     = in_data[SAMPLE_BITS + CNT_IN_BITS + MEAN_BITS +: M2_BITS];

    assign delta = AD_BITS'(mb_reg) - AD_BITS'(mean_reg);
    assign n_sum = NW'(seen_reg) + nb_reg;

    assign div_trial = {rem_reg, num_reg[DIV_BITS-1]};
    assign div_ge    = (div_trial >= {1'b0, den_reg});

    assign sq_r2    = {srem_reg, rad_reg[DIV_BITS-1 -: 2]};
    assign sq_trial = (SRW + 2)'({root_reg, 2'b01});
    assign sq_ge    = (sq_r2 >= sq_trial);

    assign rnd      = (PW + 1)'(acc_reg) + ((PW + 1)'(1) << (M2_SHIFT - 1));
    assign tot      = {1'b0, sum_reg[M2_BITS-1:0]} + {1'b0, term_reg};
    assign t_val    = quot_reg[AD_BITS-1:0];
    assign mean_new = neg_reg ? AD_BITS'(mean_reg) - t_val : AD_BITS'(mean_reg) + t_val;

    assign few = (seen_reg < CW'(2));

    always_comb
    begin
        if (few)
        begin
            spread = '0;
        end
        else if (|quot_reg[DIV_BITS-1:SPREAD_BITS + 16])
        begin
            spread = '1;
        end
        else
        begin
            spread = quot_reg[SPREAD_BITS + 15:16];
        end
        if (few)
        begin
            sd = '0;
        end
        else if (|root_reg[SQRT_BITS-1:STDEV_BITS])
        begin
            sd = '1;
        end
        else
        begin
            sd = root_reg[STDEV_BITS-1:0];
        end
    end

    assign stat.mul_done = (mplier_reg == '0);
    assign stat.refused  = refused_reg;
    assign stat.n_zero   = (n_reg == '0);
    assign stat.few      = few;

    assign out_data = out_data_reg;
    assign out_user = out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            mean_reg    <= '0;
            m2_reg      <= '0;
            refused_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                refused_reg <= (n_sum > (NW'(1) << COUNT_BITS));
            end
            if (cmd.fin_b)
            begin
                if (sum_reg[M2_BITS] || tovf_reg || tot[M2_BITS])
                begin
                    refused_reg <= 1'b1;
                end
                else
                begin
                    seen_reg <= n_reg[CW-1:0];
                    mean_reg <= mean_new[MEAN_BITS-1:0];
                    m2_reg   <= tot[M2_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            if (in_op == OP_ADD)
            begin
                nb_reg  <= NW'(1);
                mb_reg  <= {in_sample, {FRAC_BITS{1'b0}}};
                m2b_reg <= '0;
            end
            else
            begin
                nb_reg  <= NW'(in_count);
                mb_reg  <= in_mean;
                m2b_reg <= in_m2;
            end
        end
        if (cmd.load)
        begin
            neg_reg  <= delta[AD_BITS-1];
            ad_reg   <= delta[AD_BITS-1] ? AD_BITS'(-delta) : AD_BITS'(delta);
            n_reg    <= n_sum;
            quot_reg <= '0;
        end
        if (cmd.mul_go)
        begin
            acc_reg <= '0;
            case (cmd.mul_sel)
                MUL_DELTA_COUNT:
                begin
                    mcand_reg  <= PW'(ad_reg);
                    mplier_reg <= AD_BITS'(nb_reg);
                end
                MUL_DELTA_STEP:
                begin
                    mcand_reg  <= PW'(ad_reg);
                    mplier_reg <= t_val;
                end
                default:
                begin
                    mcand_reg  <= acc_reg;
                    mplier_reg <= AD_BITS'(seen_reg);
                end
            endcase
        end
        else if (cmd.mul_step)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[PW-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[AD_BITS-1:1]};
        end
        if (cmd.div_go)
        begin
            rem_reg  <= '0;
            quot_reg <= '0;
            if (cmd.div_sel == DIV_MEAN)
            begin
                num_reg <= DIV_BITS'(acc_reg + PW'(n_reg >> 1));
                den_reg <= n_reg;
            end
            else
            begin
                num_reg <= {m2_reg, {VAR_SHIFT{1'b0}}};
                den_reg <= NW'(seen_reg - CW'(1));
            end
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= div_ge ? NW'(div_trial - {1'b0, den_reg}) : div_trial[NW-1:0];
            num_reg  <= {num_reg[DIV_BITS-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_BITS-2:0], div_ge};
        end
        if (cmd.sqrt_go)
        begin
            rad_reg  <= quot_reg;
            root_reg <= '0;
            srem_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            srem_reg <= sq_ge ? SRW'(sq_r2 - sq_trial) : sq_r2[SRW-1:0];
            root_reg <= {root_reg[SQRT_BITS-2:0], sq_ge};
            rad_reg  <= {rad_reg[DIV_BITS-3:0], 2'b00};
        end
        if (cmd.fin_a)
        begin
            term_reg <= rnd[M2_SHIFT +: M2_BITS];
            tovf_reg <= |rnd[PW:M2_SHIFT + M2_BITS];
            sum_reg  <= {1'b0, m2_reg} + {1'b0, m2b_reg};
        end
        if (cmd.out_load)
        begin
            out_data_reg <= OUT_DATA_W'({sd, spread, m2_reg, mean_reg, TOTAL_BITS'(seen_reg)});
            out_user_reg <= {refused_reg, few};
        end
    end

endmodule

`default_nettype wire

/* hdl/running_mean_variance.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// running_mean_variance
// welford running mean, m2, sample variance and deviation over a stream
// ----------------------------------------------------------------------------
// One item at a time. An item runs through three shift-add multiplications
// of one multiplier bit a cycle (count, step and seen count wide), two
// 76-step restoring divisions and a 38-step square root, all on shared
// units stepped by the controller. An item that is refused for count
// overflow skips the merge arithmetic; fewer than two samples skip the
// variance and square root. The next item is taken while the last result
// still waits in the output register.
module running_mean_variance
#(
    parameter int COUNT_BITS = 20
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // sample, other_count, other_mean, other_m2
    input  wire logic [151:0]  s_axis_tdata,
    // op
    input  wire logic [0:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // total, average, sq_dev_sum, spread, std_dev
    output logic [207:0]       m_axis_tdata,
    // too_few, overflow
    output logic [1:0]         m_axis_tuser
);
    import rmv_pkg::*;

    cmd_t    cmd;
    status_t stat;

    rmv_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    rmv_datapath #(.COUNT_BITS(COUNT_BITS)) u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (s_axis_tdata),
        .in_op    (s_axis_tuser[0]),
        .out_data (m_axis_tdata),
        .out_user (m_axis_tuser)
    );

endmodule

`default_nettype wire
